// ----- rtl/core/sacm_pkg.sv -----
// Package for the SPI converter read master: phase codes, register indexes,
// reset values and the result word layout. No dependencies.
`timescale 1ns / 1ps

package sacm_pkg;

    // Widths fixed by the register map and the pin/result fields
    localparam int TICK_W   = 10;
    localparam int CMD_W    = 4;
    localparam int SAMPLE_W = 12;
    localparam int CFG_IDX_W = 4;

    // Parameter defaults
    localparam int SAMPLE_BITS_DEF  = 12;
    localparam int COMMAND_BITS_DEF = 4;

    // Register reset values
    localparam logic [TICK_W-1:0] SETUP_RST = 10'd30;
    localparam logic [TICK_W-1:0] HALF_RST  = 10'd100;
    localparam logic [TICK_W-1:0] GUARD_RST = 10'd100;
    localparam logic [CMD_W-1:0]  CMD_RST   = 4'b1000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETUP = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD   = 4'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETUP,
        PH_CMD,
        PH_SAMP,
        PH_NULL,
        PH_DATA,
        PH_GUARD
    } t_phase;

    // One result word: pin levels and status after a tick
    typedef struct packed {
        logic                sclk;
        logic                mosi;
        logic                cs_n;
        logic                busy_res;
        logic                sample_valid;
        logic [SAMPLE_W-1:0] sample;
    } t_result;

endpackage

// ----- rtl/core/spi_adc_conversion_master_unit.sv -----
// SPI master that reads one conversion from a serial converter, one timebase
// tick per input word. Depends on sacm_pkg.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------------
//  in       | to block  | i_in_valid / o_in_stall   | i_start_req, i_miso
//  out      | from block| o_out_valid / i_out_stall | o_sclk, o_mosi, o_cs_n,
//           |           |                           | o_busy_res, o_sample_valid, o_sample
//  cfg      | to block  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One input word is taken every cycle while the input is not stalled; its result word
// is formed combinationally and registered into the output register. The phase machine
// and counters update in the same cycle as the word is taken, so consecutive ticks never
// wait on each other. A stall on the output parks one result in the skid register; the
// input stalls only while that skid register is full. Reset is synchronous and
// returns all phase, counter, pin and register state to its idle values.

module spi_adc_conversion_master_unit
    import sacm_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int COMMAND_BITS = COMMAND_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_start_req,
    input  logic                 i_miso,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_sclk,
    output logic                 o_mosi,
    output logic                 o_cs_n,
    output logic                 o_busy_res,
    output logic                 o_sample_valid,
    output logic [SAMPLE_W-1:0]  o_sample,
    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TICK_W-1:0]    i_cfg_data
);

    localparam int MAX_BITS = (SAMPLE_BITS > COMMAND_BITS) ? SAMPLE_BITS : COMMAND_BITS;
    localparam int BIT_W    = $clog2(MAX_BITS + 1);

    // configuration registers
    logic [TICK_W-1:0] r_setup_ticks, r_half_ticks, r_guard_ticks;
    logic [CMD_W-1:0]  r_cmd_bits;

    // conversion state
    t_phase                   r_phase, n_phase;
    logic [TICK_W-1:0]        r_tick, n_tick;
    logic [BIT_W-1:0]         r_bit, n_bit;
    logic [SAMPLE_BITS-1:0]   r_shift_in, n_shift_in;
    logic [COMMAND_BITS-1:0]  r_cmd_shift, n_cmd_shift;
    logic                     r_pin_sclk, n_pin_sclk;
    logic                     r_pin_mosi, n_pin_mosi;
    logic                     r_pin_cs, n_pin_cs;
    logic [SAMPLE_BITS-1:0]   r_last, n_last;
    logic                     w_valid;

    // output register and skid
    t_result r_out, r_skid, w_res;
    logic    r_out_valid, r_skid_valid;

    logic                    w_in_acc, w_out_take;
    logic [TICK_W-1:0]       w_dur, w_tick_inc;
    logic                    w_done;
    logic [BIT_W-1:0]        w_bit_inc;
    logic [COMMAND_BITS+CMD_W-1:0] w_cmd_ext;
    logic [COMMAND_BITS-1:0] w_cmd_sh;
    logic [SAMPLE_BITS+SAMPLE_W-1:0] w_last_ext;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign w_in_acc    = i_in_valid && !r_skid_valid;
    assign w_out_take  = r_out_valid && !i_out_stall;

    // register writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup_ticks <= SETUP_RST;
            r_half_ticks  <= HALF_RST;
            r_guard_ticks <= GUARD_RST;
            r_cmd_bits    <= CMD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SETUP: r_setup_ticks <= i_cfg_data;
                CFG_HALF:  r_half_ticks  <= i_cfg_data;
                CFG_GUARD: r_guard_ticks <= i_cfg_data;
                CFG_CMD:   r_cmd_bits    <= i_cfg_data[CMD_W-1:0];
                default: ;
            endcase
        end
    end

    // delay counter: done when the count reaches the duration or wraps;
    // a zero duration therefore acts like one tick
    always_comb begin
        case (r_phase)
            PH_SETUP: w_dur = r_setup_ticks;
            PH_GUARD: w_dur = r_guard_ticks;
            default:  w_dur = r_half_ticks;
        endcase
        w_tick_inc = r_tick + 1'b1;
        w_done     = (w_tick_inc >= w_dur) || (w_tick_inc == '0);
    end

    assign w_bit_inc = r_bit + 1'b1;
    assign w_cmd_ext = {{COMMAND_BITS{1'b0}}, r_cmd_bits};
    assign w_cmd_sh  = r_cmd_shift >> r_bit;

    // next phase and counters
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_phase = PH_SETUP;
                    n_tick  = '0;
                    n_bit   = '0;
                end
            end
            PH_SETUP: begin
                n_tick = w_done ? '0 : w_tick_inc;
                if (w_done) begin
                    n_phase = PH_CMD;
                    n_bit   = '0;
                end
            end
            PH_CMD, PH_SAMP, PH_NULL, PH_DATA: begin
                n_tick = w_done ? '0 : w_tick_inc;
                if (w_done) begin
                    if (r_pin_sclk) begin
                        // falling edge: end of transfer after the last data bit
                        if (r_phase == PH_DATA && r_bit >= BIT_W'(SAMPLE_BITS))
                            n_phase = PH_GUARD;
                    end else begin
                        // rising edge
                        case (r_phase)
                            PH_CMD: begin
                                if (w_bit_inc >= BIT_W'(COMMAND_BITS)) begin
                                    n_bit   = '0;
                                    n_phase = PH_SAMP;
                                end else begin
                                    n_bit = w_bit_inc;
                                end
                            end
                            PH_SAMP: n_phase = PH_NULL;
                            PH_NULL: begin
                                n_bit   = '0;
                                n_phase = PH_DATA;
                            end
                            default: n_bit = w_bit_inc;
                        endcase
                    end
                end
            end
            default: begin
                n_tick = w_done ? '0 : w_tick_inc;
                if (w_done)
                    n_phase = PH_IDLE;
            end
        endcase
    end

    // pin levels, shift registers and the finished sample
    always_comb begin
        n_pin_sclk  = r_pin_sclk;
        n_pin_mosi  = r_pin_mosi;
        n_pin_cs    = r_pin_cs;
        n_cmd_shift = r_cmd_shift;
        n_shift_in  = r_shift_in;
        n_last      = r_last;
        w_valid     = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    n_pin_sclk  = 1'b0;
                    n_pin_cs    = 1'b0;
                    n_pin_mosi  = 1'b1;
                    n_cmd_shift = w_cmd_ext[COMMAND_BITS-1:0];
                    n_shift_in  = '0;
                end
            end
            PH_SETUP: begin
                if (w_done)
                    n_pin_sclk = 1'b1;
            end
            PH_CMD, PH_SAMP, PH_NULL, PH_DATA: begin
                if (w_done) begin
                    n_pin_sclk = !r_pin_sclk;
                    if (r_pin_sclk) begin
                        if (r_phase == PH_CMD && r_bit < BIT_W'(COMMAND_BITS))
                            n_pin_mosi = w_cmd_sh[0];
                        else if (r_phase == PH_DATA && r_bit >= BIT_W'(SAMPLE_BITS))
                            n_pin_cs = 1'b1;
                    end else if (r_phase == PH_DATA) begin
                        n_shift_in = {r_shift_in[SAMPLE_BITS-2:0], i_miso};
                    end
                end
            end
            default: begin
                if (w_done) begin
                    n_last  = r_shift_in;
                    w_valid = 1'b1;
                end
            end
        endcase
    end

    assign w_last_ext = {{SAMPLE_W{1'b0}}, n_last};

    always_comb begin
        w_res.sclk         = n_pin_sclk;
        w_res.mosi         = n_pin_mosi;
        w_res.cs_n         = n_pin_cs;
        w_res.busy_res     = (n_phase != PH_IDLE);
        w_res.sample_valid = w_valid;
        w_res.sample       = w_last_ext[SAMPLE_W-1:0];
    end

    // advance state on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_shift_in  <= '0;
            r_cmd_shift <= '0;
            r_pin_sclk  <= 1'b0;
            r_pin_mosi  <= 1'b0;
            r_pin_cs    <= 1'b1;
            r_last      <= '0;
        end else if (w_in_acc) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_bit       <= n_bit;
            r_shift_in  <= n_shift_in;
            r_cmd_shift <= n_cmd_shift;
            r_pin_sclk  <= n_pin_sclk;
            r_pin_mosi  <= n_pin_mosi;
            r_pin_cs    <= n_pin_cs;
            r_last      <= n_last;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (w_out_take) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (w_in_acc) begin
                if (r_out_valid && !w_out_take)
                    r_skid_valid <= 1'b1;
                else
                    r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // move result words
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_take)
                r_out <= r_skid;
        end else if (w_in_acc) begin
            if (r_out_valid && !w_out_take)
                r_skid <= w_res;
            else
                r_out <= w_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sclk         = r_out.sclk;
    assign o_mosi         = r_out.mosi;
    assign o_cs_n         = r_out.cs_n;
    assign o_busy_res     = r_out.busy_res;
    assign o_sample_valid = r_out.sample_valid;
    assign o_sample       = r_out.sample;

    // skid holds a word only behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");

    // chip select is released whenever the master is idle
    a_idle_cs_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> r_pin_cs)
        else $error("chip select active while idle");

    // clock high only inside a selected transfer
    a_sclk_in_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pin_sclk |-> !r_pin_cs)
        else $error("serial clock high with chip select released");

    // a finished sample is presented only as the master goes idle
    a_valid_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.sample_valid) |-> (!r_out.busy_res && r_out.cs_n))
        else $error("sample presented while busy");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for spi_adc_conversion_master_unit: drives timebase
// ticks and register writes, predicts every pin/status word and checks it.
// Depends on sacm_pkg and spi_adc_conversion_master_unit.
`timescale 1ns / 1ps

module tb;
    import sacm_pkg::*;

    localparam int CMD_BITS    = COMMAND_BITS_DEF;
    localparam int SMP_BITS    = SAMPLE_BITS_DEF;
    localparam int QUIET_LIMIT = 1000;
    localparam int SETTING_CNT = 4;
    localparam int DIR_ROWS    = 20;
    localparam logic [TICK_W-1:0]    TICK_MAX     = {TICK_W{1'b1}};
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = {CFG_IDX_W{1'b1}};

    // Pin/status words that can be read straight off the timing rules
    localparam t_result IDLE_PINS = '{sclk: 1'b0, mosi: 1'b0, cs_n: 1'b1, busy_res: 1'b0,
                                      sample_valid: 1'b0, sample: '0};
    localparam t_result SETUP_PINS = '{sclk: 1'b0, mosi: 1'b1, cs_n: 1'b0, busy_res: 1'b1,
                                       sample_valid: 1'b0, sample: '0};

    typedef struct packed {
        logic    start;
        logic    miso;
        logic    typed;
        t_result pins;
    } t_dir_row;

    // Directed ticks under the reset setup, guard and command values with a
    // one-tick half period: idle, start, then starts while busy during the
    // setup wait; the last rows go through the predictor.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{1'b0, 1'b0, 1'b1, IDLE_PINS},
        '{1'b0, 1'b1, 1'b1, IDLE_PINS},
        '{1'b1, 1'b1, 1'b1, SETUP_PINS},
        '{1'b1, 1'b0, 1'b1, SETUP_PINS},
        '{1'b1, 1'b1, 1'b1, SETUP_PINS},
        '{1'b0, 1'b0, 1'b1, SETUP_PINS},
        '{1'b0, 1'b1, 1'b1, SETUP_PINS},
        '{1'b1, 1'b0, 1'b1, SETUP_PINS},
        '{1'b1, 1'b1, 1'b1, SETUP_PINS},
        '{1'b0, 1'b0, 1'b1, SETUP_PINS},
        '{1'b0, 1'b0, 1'b1, SETUP_PINS},
        '{1'b1, 1'b1, 1'b1, SETUP_PINS},
        '{1'b0, 1'b1, 1'b1, SETUP_PINS},
        '{1'b1, 1'b0, 1'b1, SETUP_PINS},
        '{1'b0, 1'b1, 1'b1, SETUP_PINS},
        '{1'b1, 1'b1, 1'b1, SETUP_PINS},
        '{1'b0, 1'b0, 1'b0, IDLE_PINS},
        '{1'b1, 1'b1, 1'b0, IDLE_PINS},
        '{1'b0, 1'b1, 1'b0, IDLE_PINS},
        '{1'b1, 1'b0, 1'b0, IDLE_PINS}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_start_req = 1'b0;
    logic                 i_miso      = 1'b0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [TICK_W-1:0]    i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_sclk;
    logic                 o_mosi;
    logic                 o_cs_n;
    logic                 o_busy_res;
    logic                 o_sample_valid;
    logic [SAMPLE_W-1:0]  o_sample;
    logic                 o_cfg_ready;

    spi_adc_conversion_master_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_start_req    (i_start_req),
        .i_miso         (i_miso),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sclk         (o_sclk),
        .o_mosi         (o_mosi),
        .o_cs_n         (o_cs_n),
        .o_busy_res     (o_busy_res),
        .o_sample_valid (o_sample_valid),
        .o_sample       (o_sample),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Register mirror
    logic [TICK_W-1:0] cfg_setup = SETUP_RST;
    logic [TICK_W-1:0] cfg_half  = HALF_RST;
    logic [TICK_W-1:0] cfg_guard = GUARD_RST;
    logic [CMD_W-1:0]  cfg_cmd   = CMD_RST;

    // Transfer state of the predictor
    t_phase              ph          = PH_IDLE;
    logic [TICK_W-1:0]   tick_cnt    = '0;
    logic [4:0]          bit_cnt     = '0;
    logic [SAMPLE_W-1:0] shift_acc   = '0;
    logic [CMD_W-1:0]    cmd_latch   = '0;
    logic                pin_sclk    = 1'b0;
    logic                pin_mosi    = 1'b0;
    logic                pin_cs      = 1'b1;
    logic [SAMPLE_W-1:0] held_sample = '0;

    t_result due_pins [$];
    int      fail_count   = 0;
    int      samples_done = 0;
    int      quiet_cycles = 0;
    int      stall_left   = 0;
    bit      tx_jitter    = 1'b0;
    bit      rx_jitter    = 1'b1;

    // Count one tick of a delay; true when dur ticks have passed (0 acts as 1)
    function automatic logic delay_over(input logic [TICK_W-1:0] dur);
        logic [TICK_W-1:0] nxt;
        nxt = tick_cnt + 1'b1;
        if (nxt >= dur || nxt == '0) begin
            tick_cnt = '0;
            return 1'b1;
        end
        tick_cnt = nxt;
        return 1'b0;
    endfunction

    // Advance the transfer by one tick and form the pin/status word
    task automatic advance_tick(input logic start, input logic miso, output t_result pins);
        logic done_now;
        done_now = 1'b0;
        case (ph)
            PH_IDLE: begin
                if (start) begin
                    pin_sclk  = 1'b0;
                    pin_cs    = 1'b0;
                    pin_mosi  = 1'b1;
                    cmd_latch = cfg_cmd;
                    shift_acc = '0;
                    bit_cnt   = '0;
                    tick_cnt  = '0;
                    ph        = PH_SETUP;
                end
            end
            PH_SETUP: begin
                if (delay_over(cfg_setup)) begin
                    pin_sclk = 1'b1;
                    bit_cnt  = '0;
                    ph       = PH_CMD;
                end
            end
            PH_GUARD: begin
                if (delay_over(cfg_guard)) begin
                    held_sample = shift_acc;
                    done_now    = 1'b1;
                    ph          = PH_IDLE;
                end
            end
            default: begin
                if (delay_over(cfg_half)) begin
                    if (pin_sclk) begin
                        // falling edge: set up a command bit or close the frame
                        pin_sclk = 1'b0;
                        if (ph == PH_CMD && bit_cnt < CMD_BITS) begin
                            pin_mosi = cmd_latch[bit_cnt[1:0]];
                        end else if (ph == PH_DATA && bit_cnt >= SMP_BITS) begin
                            pin_cs = 1'b1;
                            ph     = PH_GUARD;
                        end
                    end else begin
                        // rising edge: count command bits, read data MSB first
                        pin_sclk = 1'b1;
                        case (ph)
                            PH_CMD: begin
                                bit_cnt = bit_cnt + 1'b1;
                                if (bit_cnt >= CMD_BITS) begin
                                    bit_cnt = '0;
                                    ph      = PH_SAMP;
                                end
                            end
                            PH_SAMP: ph = PH_NULL;
                            PH_NULL: begin
                                bit_cnt = '0;
                                ph      = PH_DATA;
                            end
                            default: begin
                                shift_acc = {shift_acc[SAMPLE_W-2:0], miso};
                                bit_cnt   = bit_cnt + 1'b1;
                            end
                        endcase
                    end
                end
            end
        endcase
        pins = '{sclk: pin_sclk, mosi: pin_mosi, cs_n: pin_cs, busy_res: (ph != PH_IDLE),
                 sample_valid: done_now, sample: held_sample};
    endtask

    function automatic void note_field(input string tag, input int unsigned want,
                                       input int unsigned seen);
        if (want != seen) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, seen);
            fail_count++;
        end
    endfunction

    // Send one tick word and hold it until taken; return the predicted word
    task automatic send_tick(input logic start, input logic miso, output t_result pins);
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_start_req <= start;
        i_miso      <= miso;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_tick(start, miso, pins);
        if (pins.sample_valid) samples_done++;
    endtask

    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop valid and wait for every outstanding word
    task automatic await_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_pins.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SETUP: cfg_setup = data;
            CFG_HALF:  cfg_half  = data;
            CFG_GUARD: cfg_guard = data;
            CFG_CMD:   cfg_cmd   = data[CMD_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [TICK_W-1:0] setup, input logic [TICK_W-1:0] half,
                                 input logic [TICK_W-1:0] guard, input logic [TICK_W-1:0] cmd);
        write_reg(CFG_SETUP, setup);
        write_reg(CFG_HALF, half);
        write_reg(CFG_GUARD, guard);
        write_reg(CFG_CMD, cmd);
    endtask

    // Random ticks until n more conversions have completed
    task automatic run_conversions(input int n);
        int      goal;
        t_result pins;
        goal = samples_done + n;
        while (samples_done < goal) begin
            if (tx_jitter && $urandom_range(0, 7) == 0) hold_off($urandom_range(1, 12));
            if ($urandom_range(0, 79) == 0) await_results();
            send_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)), pins);
            due_pins.push_back(pins);
        end
    endtask

    // Output stall in random bursts
    always @(negedge i_clk) begin
        if (stall_left == 0 && rx_jitter && $urandom_range(0, 11) == 0)
            stall_left = $urandom_range(1, 12);
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Check each accepted word against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_pins.size() == 0) begin
                $display("%0t: word with nothing expected, actual sclk %0b mosi %0b cs_n %0b",
                         $time, o_sclk, o_mosi, o_cs_n);
                fail_count++;
            end else begin
                want = due_pins.pop_front();
                note_field("sclk", 32'(want.sclk), 32'(o_sclk));
                note_field("mosi", 32'(want.mosi), 32'(o_mosi));
                note_field("cs_n", 32'(want.cs_n), 32'(o_cs_n));
                note_field("busy_res", 32'(want.busy_res), 32'(o_busy_res));
                note_field("sample_valid", 32'(want.sample_valid), 32'(o_sample_valid));
                note_field("sample", 32'(want.sample), 32'(o_sample));
            end
        end
    end

    // Watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("spi_adc_conversion_master_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_result pins;
        int      goal_n;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Shorten the clock half period; setup, guard and command keep reset values
        write_reg(CFG_HALF, 10'd1);

        // Directed ticks, then finish that first transfer
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_tick(dir_rows[r].start, dir_rows[r].miso, pins);
            due_pins.push_back(dir_rows[r].typed ? dir_rows[r].pins : pins);
        end
        tx_jitter = 1'b1;
        run_conversions(1);

        // Register settings: zero delays, all ones, then small random ones
        for (int k = 0; k < SETTING_CNT; k++) begin
            await_results();
            tx_jitter = (k != SETTING_CNT - 1) && ($urandom_range(0, 3) != 0);
            rx_jitter = (k != SETTING_CNT - 1) && ($urandom_range(0, 3) != 0);
            goal_n = 1;
            case (k)
                0: begin
                    apply_setting('0, '0, '0, '0);
                    goal_n = 2;
                end
                1: apply_setting(10'd1, 10'd1, 10'd1, TICK_MAX);
                default: begin
                    // indexes past the map must leave every register alone
                    if (k == 2) begin
                        write_reg(CFG_IDX_LAST, TICK_W'($urandom_range(0, TICK_MAX)));
                        write_reg(CFG_IDX_W'($urandom_range(CFG_CMD + 1, CFG_IDX_LAST)),
                                  TICK_W'($urandom_range(0, TICK_MAX)));
                    end
                    apply_setting(TICK_W'($urandom_range(0, 3)), TICK_W'($urandom_range(0, 3)),
                                  TICK_W'($urandom_range(0, 3)),
                                  TICK_W'($urandom_range(0, TICK_MAX)));
                end
            endcase
            run_conversions(goal_n);
        end

        await_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("spi_adc_conversion_master_unit test passed");
        end else begin
            $display("spi_adc_conversion_master_unit test failed");
        end
        $finish;
    end

endmodule
